FILE: rtl/clcd_pkg.sv
// shared types and constants for the character lcd controller
// no dependencies; used by clcd_ctrl, clcd_store and char_lcd_controller
`default_nettype none

package clcd_pkg;

  localparam int MAX_ROWS    = 4;
  localparam int MAX_COLS    = 40;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // register offsets on the bus
  localparam logic [1:0] OFF_DATA = 2'd0;
  localparam logic [1:0] OFF_CTRL = 2'd1;

  // configuration register indexes
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [2:0] ROW_COUNT_RST = 3'd2;
  localparam logic [5:0] COL_COUNT_RST = 6'd16;

  // command bytes
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;

  // ddram row base addresses, tried in this order
  localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CHAR  = 2'd1,
    EV_CLEAR = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [1:0]  row;
    logic [5:0]  col;
    logic [7:0]  chr;
    logic [1:0]  cur_row;
    logic [5:0]  cur_col;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              clear;
  } store_req_t;

endpackage

`default_nettype wire

FILE: rtl/char_lcd_controller.sv
// top level of the character lcd controller: handshakes, config, result register
// depends on clcd_pkg, clcd_ctrl and clcd_store
`default_nettype none

// Character LCD controller with a bus-style register front end. Each input
// beat is one register write: offset 0 loads the data latch, offset 1 loads
// the control bits (bit 0 RS, bit 1 RW, bit 2 E). A falling edge of E with RW
// low acts on the latched byte: with RS high the byte is stored at the cursor
// in a 160-entry character memory and the cursor advances, wrapping to the
// next row; with RS low, 0x01 clears the memory and homes the cursor, 0x02
// homes the cursor, and a byte with bit 7 set moves the cursor to a ddram
// address. Every input beat gives exactly one output beat, which reports a
// display event and the cursor after the access. An ordinary beat is
// registered into the output register, and the next beat is taken in the
// same cycle the previous result leaves. The character memory has a single
// write port and is wiped one entry per cycle: after reset and after each
// clear command the input is stalled while the sweep runs.
// row_count and col_count are written through the config port at any time
// (ready is always high) and should only change while the block is idle.

module char_lcd_controller (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  reg_offset,
  input  wire logic [31:0] write_value,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_kind,
  output logic [1:0]       event_row,
  output logic [5:0]       event_col,
  output logic [7:0]       event_char,
  output logic [1:0]       cursor_row_now,
  output logic [5:0]       cursor_col_now,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  logic                  accept;
  logic                  store_busy;
  logic [2:0]            row_count;
  logic [5:0]            col_count;
  clcd_pkg::result_t     result;
  clcd_pkg::result_t     out_reg;
  clcd_pkg::store_req_t  store_req;

  // config registers, writes always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= clcd_pkg::ROW_COUNT_RST;
      col_count <= clcd_pkg::COL_COUNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == clcd_pkg::REG_ROW_COUNT) begin
        row_count <= cfg_data[2:0];
      end else begin
        col_count <= cfg_data;
      end
    end
  end

  // hold off input while the memory sweep runs or the result beat is stuck
  assign in_stall = store_busy | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  clcd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .reg_offset  (reg_offset),
    .write_value (write_value),
    .row_count   (row_count),
    .col_count   (col_count),
    .result      (result),
    .store_req   (store_req)
  );

  clcd_store u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (store_req),
    .busy (store_busy)
  );

  // output register: loaded on accept, emptied when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign event_kind     = out_reg.kind;
  assign event_row      = out_reg.row;
  assign event_col      = out_reg.col;
  assign event_char     = out_reg.chr;
  assign cursor_row_now = out_reg.cur_row;
  assign cursor_col_now = out_reg.cur_col;

endmodule

`default_nettype wire

FILE: rtl/clcd_store.sv
// character store: one synchronous memory plus its clearing sweep
// depends on clcd_pkg
`default_nettype none

module clcd_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire clcd_pkg::store_req_t req,
  output logic                     busy
);

  logic [7:0] mem [clcd_pkg::STORE_DEPTH];

  logic                        clearing;
  logic [clcd_pkg::ADDR_W-1:0] ptr;

  // sweep state: starts after reset and after a clear command
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      ptr      <= '0;
    end else if (req.clear) begin
      clearing <= 1'b1;
      ptr      <= '0;
    end else if (clearing) begin
      if (ptr == clcd_pkg::ADDR_W'(clcd_pkg::STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      ptr <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[ptr] <= 8'h00;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  assign busy = clearing;

endmodule

`default_nettype wire

FILE: rtl/clcd_ctrl.sv
// bus latches, cursor and command decode
// depends on clcd_pkg; drives write and clear requests to clcd_store
`default_nettype none

module clcd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [1:0]           reg_offset,
  input  wire logic [31:0]          write_value,
  input  wire logic [2:0]           row_count,
  input  wire logic [5:0]           col_count,
  output clcd_pkg::result_t         result,
  output clcd_pkg::store_req_t      store_req
);

  logic [7:0] data_latch;
  logic [2:0] control_latch;
  logic [1:0] cursor_row;
  logic [5:0] cursor_col;

  logic [7:0] data_latch_next;
  logic [2:0] control_latch_next;
  logic [1:0] cursor_row_next;
  logic [5:0] cursor_col_next;

  logic [2:0] rows;
  logic [5:0] cols;
  logic       fall;
  logic [6:0] col_inc;
  logic       map_hit;
  logic [1:0] map_row;
  logic [7:0] map_off;
  logic [5:0] map_col;

  // small modulo for values up to 4
  function automatic logic [1:0] row_mod(input logic [2:0] v, input logic [2:0] r);
    logic [2:0] t;
    t = v;
    for (int i = 0; i < clcd_pkg::MAX_ROWS; i++) begin
      if (t >= r) t = t - r;
    end
    return t[1:0];
  endfunction

  // effective sizes after clamping
  always_comb begin
    if (row_count == 3'd0) rows = 3'd1;
    else if (row_count > 3'(clcd_pkg::MAX_ROWS)) rows = 3'(clcd_pkg::MAX_ROWS);
    else rows = row_count;
    if (col_count == 6'd0) cols = 6'd1;
    else if (col_count > 6'(clcd_pkg::MAX_COLS)) cols = 6'(clcd_pkg::MAX_COLS);
    else cols = col_count;
  end

  // ddram address to row and column, first matching row wins
  always_comb begin
    map_hit = 1'b0;
    map_row = 2'd0;
    map_off = 8'd0;
    for (int i = 0; i < clcd_pkg::MAX_ROWS; i++) begin
      if (!map_hit && (3'(i) < rows)
          && ({1'b0, data_latch[6:0]} >= clcd_pkg::ROW_BASE[i])
          && ({1'b0, data_latch[6:0]} < clcd_pkg::ROW_BASE[i] + 8'(clcd_pkg::MAX_COLS))) begin
        map_hit = 1'b1;
        map_row = 2'(i);
        map_off = {1'b0, data_latch[6:0]} - clcd_pkg::ROW_BASE[i];
      end
    end
    map_col = (map_off[5:0] >= cols) ? cols - 6'd1 : map_off[5:0];
  end

  assign fall    = (reg_offset == clcd_pkg::OFF_CTRL) && control_latch[2]
                   && !write_value[2] && !write_value[1];
  assign col_inc = {1'b0, cursor_col} + 7'd1;

  always_comb begin
    data_latch_next    = data_latch;
    control_latch_next = control_latch;
    cursor_row_next    = cursor_row;
    cursor_col_next    = cursor_col;
    result             = '0;
    result.kind        = clcd_pkg::EV_NONE;
    store_req          = '0;
    store_req.wr_addr  = clcd_pkg::ADDR_W'(cursor_row) * clcd_pkg::ADDR_W'(clcd_pkg::MAX_COLS)
                         + clcd_pkg::ADDR_W'(cursor_col);
    store_req.wr_data  = data_latch;

    if (reg_offset == clcd_pkg::OFF_DATA) begin
      data_latch_next = write_value[7:0];
    end else if (reg_offset == clcd_pkg::OFF_CTRL) begin
      control_latch_next = write_value[2:0];
    end

    if (fall) begin
      if (write_value[0]) begin
        // character write, dropped if the cursor sits past the columns
        if (cursor_col < cols) begin
          store_req.wr_en = 1'b1;
          result.kind     = clcd_pkg::EV_CHAR;
          result.row      = cursor_row;
          result.col      = cursor_col;
          result.chr      = data_latch;
          if (col_inc >= {1'b0, cols}) begin
            cursor_col_next = 6'd0;
            cursor_row_next = row_mod({1'b0, cursor_row} + 3'd1, rows);
          end else begin
            cursor_col_next = col_inc[5:0];
          end
        end
      end else if (data_latch == clcd_pkg::CMD_CLEAR) begin
        store_req.clear = 1'b1;
        cursor_row_next = 2'd0;
        cursor_col_next = 6'd0;
        result.kind     = clcd_pkg::EV_CLEAR;
      end else if (data_latch == clcd_pkg::CMD_HOME) begin
        cursor_row_next = 2'd0;
        cursor_col_next = 6'd0;
      end else if (data_latch[7] && map_hit) begin
        cursor_row_next = map_row;
        cursor_col_next = map_col;
      end
    end

    result.cur_row = cursor_row_next;
    result.cur_col = cursor_col_next;

    if (!accept) begin
      store_req.wr_en = 1'b0;
      store_req.clear = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_latch    <= 8'd0;
      control_latch <= 3'd0;
      cursor_row    <= 2'd0;
      cursor_col    <= 6'd0;
    end else if (accept) begin
      data_latch    <= data_latch_next;
      control_latch <= control_latch_next;
      cursor_row    <= cursor_row_next;
      cursor_col    <= cursor_col_next;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_char_lcd_controller.sv
// testbench for char_lcd_controller: predicts the display event and cursor of every
// bus beat and checks each output beat against it, field by field
// depends on clcd_pkg and the char_lcd_controller rtl
`timescale 1ns / 1ps

module tb_char_lcd_controller;
  import clcd_pkg::*;

  localparam int CLK_HALF    = 2;
  // worst case is every beat a clear (a full memory sweep) plus long gaps and stalls,
  // taken a few times over
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 90;
  localparam int DRAIN_TAIL  = 8;

  // offsets the block ignores
  localparam logic [1:0] OFF_SPARE_A = 2'd2;
  localparam logic [1:0] OFF_SPARE_B = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  reg_offset;
  logic [31:0] write_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  event_kind;
  logic [1:0]  event_row;
  logic [5:0]  event_col;
  logic [7:0]  event_char;
  logic [1:0]  cursor_row_now;
  logic [5:0]  cursor_col_now;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [5:0]  cfg_data;

  char_lcd_controller dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .reg_offset     (reg_offset),
    .write_value    (write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_kind     (event_kind),
    .event_row      (event_row),
    .event_col      (event_col),
    .event_char     (event_char),
    .cursor_row_now (cursor_row_now),
    .cursor_col_now (cursor_col_now),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // shadow of the display controller state
  // ---------------------------------------------------------------------------
  logic [2:0] row_count_q;
  logic [5:0] col_count_q;
  logic [7:0] data_byte;
  logic [2:0] ctrl_bits;       // {e, rw, rs}
  logic [1:0] cur_row;
  logic [5:0] cur_col;
  logic [7:0] char_mem [STORE_DEPTH];

  // display events still owed by the block, oldest first
  result_t display_events_due [$];

  int mismatches;
  int cycles;
  int burst_left;
  int bus_beats;               // beats at offsets 0 and 1 only

  stall_mode_t stall_mode;
  int          stall_left;

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor: one bus beat in, one display event out
  // ---------------------------------------------------------------------------
  function automatic result_t advance_display(input logic [1:0] off, input logic [31:0] val);
    result_t    r;
    int         rows;
    int         cols;
    logic       was_e;
    logic [6:0] addr;
    bit         found;
    r = '0;
    r.kind = EV_NONE;
    // out-of-range counts clamp into the legal span
    rows = (row_count_q == 0) ? 1 : (row_count_q > MAX_ROWS) ? MAX_ROWS : int'(row_count_q);
    cols = (col_count_q == 0) ? 1 : (col_count_q > MAX_COLS) ? MAX_COLS : int'(col_count_q);
    if (off == OFF_DATA) begin
      data_byte = val[7:0];
    end else if (off == OFF_CTRL) begin
      was_e = ctrl_bits[2];
      ctrl_bits = val[2:0];
      // act only on e falling with rw low
      if (was_e && !ctrl_bits[2] && !ctrl_bits[1]) begin
        if (ctrl_bits[0]) begin
          // cursor beyond the columns in use drops the character
          if (cur_col < cols) begin
            char_mem[int'(cur_row) * MAX_COLS + int'(cur_col)] = data_byte;
            r.kind = EV_CHAR;
            r.row  = cur_row;
            r.col  = cur_col;
            r.chr  = data_byte;
            if (int'(cur_col) + 1 >= cols) begin
              cur_col = '0;
              cur_row = 2'((int'(cur_row) + 1) % rows);
            end else begin
              cur_col = cur_col + 6'd1;
            end
          end
        end else if (data_byte == CMD_CLEAR) begin
          foreach (char_mem[k]) char_mem[k] = 8'h00;
          cur_row = '0;
          cur_col = '0;
          r.kind  = EV_CLEAR;
        end else if (data_byte == CMD_HOME) begin
          cur_row = '0;
          cur_col = '0;
        end else if (data_byte[7]) begin
          // first row base whose span holds the address wins, column clamped
          addr  = data_byte[6:0];
          found = 1'b0;
          for (int i = 0; i < rows; i++) begin
            if (!found && addr >= ROW_BASE[i] && addr < ROW_BASE[i] + MAX_COLS) begin
              found   = 1'b1;
              cur_row = 2'(i);
              cur_col = 6'((addr - ROW_BASE[i] >= cols) ? cols - 1 : addr - ROW_BASE[i]);
            end
          end
        end
      end
    end
    r.cur_row = cur_row;
    r.cur_col = cur_col;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall pattern and checker
  // ---------------------------------------------------------------------------
  // stall mode changes at random intervals, including stretches with no stall
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 80);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= stall_left[2];
      default:        out_stall <= 1'b0;
    endcase
  end

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (display_events_due.size() == 0) begin
        report("beat with no event due", event_kind, -1);
      end else begin
        want = display_events_due.pop_front();
        if (event_kind !== want.kind)        report("event_kind", event_kind, want.kind);
        if (event_row !== want.row)          report("event_row", event_row, want.row);
        if (event_col !== want.col)          report("event_col", event_col, want.col);
        if (event_char !== want.chr)         report("event_char", event_char, want.chr);
        if (cursor_row_now !== want.cur_row) report("cursor_row_now", cursor_row_now, want.cur_row);
        if (cursor_col_now !== want.cur_col) report("cursor_col_now", cursor_col_now, want.cur_col);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // words with random upper bits so every bit of write_value toggles
  function automatic logic [31:0] data_word(input logic [7:0] b);
    logic [31:0] w;
    w = $urandom;
    w[7:0] = b;
    return w;
  endfunction

  function automatic logic [31:0] ctrl_word(input bit rs, input bit rw, input bit e);
    logic [31:0] w;
    w = $urandom;
    w[2:0] = {e, rw, rs};
    return w;
  endfunction

  // one bus beat; the sender runs in bursts with random gaps between them
  task automatic send_beat(input logic [1:0] off, input logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    reg_offset  <= off;
    write_value <= val;
    do @(posedge clk); while (in_stall);
    display_events_due.push_back(advance_display(off, val));
    if (off == OFF_DATA || off == OFF_CTRL) bus_beats++;
  endtask

  task automatic idle_in;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // e high then e low; sometimes e is held over an extra beat or the byte is
  // rewritten while e is high
  task automatic strobe(input bit rs, input bit rw);
    int roll;
    send_beat(OFF_CTRL, ctrl_word(rs, rw, 1'b1));
    roll = $urandom_range(0, 19);
    if (roll < 2) send_beat(OFF_CTRL, ctrl_word(rs, rw, 1'b1));
    else if (roll == 2) send_beat(OFF_DATA, $urandom);
    send_beat(OFF_CTRL, ctrl_word(rs, rw, 1'b0));
  endtask

  task automatic put_char(input logic [7:0] b);
    send_beat(OFF_DATA, data_word(b));
    strobe(1'b1, 1'b0);
  endtask

  task automatic issue_command(input logic [7:0] b);
    send_beat(OFF_DATA, data_word(b));
    strobe(1'b0, 1'b0);
  endtask

  // register writes only once every owed event has come back
  task automatic write_reg(input logic idx, input logic [5:0] value);
    idle_in();
    while (display_events_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROW_COUNT) row_count_q = value[2:0];
    else col_count_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_sequence;
    int         roll;
    logic [7:0] b;
    logic [6:0] addr;
    roll = $urandom_range(0, 99);
    b = 8'($urandom);
    if (roll < 45) begin
      put_char(b);
    end else if (roll < 50) begin
      issue_command(CMD_CLEAR);
    end else if (roll < 56) begin
      issue_command(CMD_HOME);
    end else if (roll < 78) begin
      // addresses mostly near a row base so both matches and misses occur
      if ($urandom_range(0, 3) == 0) addr = 7'($urandom);
      else addr = 7'(ROW_BASE[$urandom_range(0, 3)] + $urandom_range(0, 44));
      issue_command({1'b1, addr});
    end else if (roll < 84) begin
      b[7] = 1'b0;
      issue_command(b);
    end else if (roll < 91) begin
      // read request: falling edge with rw high
      send_beat(OFF_DATA, data_word(b));
      strobe(1'($urandom_range(0, 1)), 1'b1);
    end else begin
      // loose beat on any offset
      send_beat(2'($urandom_range(0, 3)), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // ignored offsets, read request, control write without an edge
  task automatic test_bus_decode;
    send_beat(OFF_SPARE_A, 32'hFFFF_FFFF);
    send_beat(OFF_SPARE_B, 32'h0000_0000);
    send_beat(OFF_DATA, 32'hFFFF_FFFF);
    send_beat(OFF_CTRL, 32'hFFFF_FFFF);
    send_beat(OFF_CTRL, {29'h1FFF_FFFF, 3'b010});
    send_beat(OFF_CTRL, 32'h0000_0000);
  endtask

  task automatic test_characters;
    put_char(8'h00);
    put_char(8'hFF);
  endtask

  // home, address move to row 1 col 5, command without bit 7, clear
  task automatic test_commands;
    issue_command(CMD_HOME);
    issue_command(8'hC5);
    issue_command(8'h7F);
    issue_command(CMD_CLEAR);
  endtask

  // phases of random traffic under changing register settings; the cursor is
  // kept across phases so shrinking counts leave it out of range
  task automatic test_random_traffic;
    int         start;
    logic [2:0] rows;
    logic [5:0] cols;
    logic [5:0] pad;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin rows = 3'd0; cols = 6'd0;  end
        1: begin rows = 3'd7; cols = 6'd63; end
        2: begin rows = 3'd1; cols = 6'd1;  end
        3: begin rows = 3'd4; cols = 6'd40; end
        4: begin rows = 3'd5; cols = 6'd41; end
        default: begin
          rows = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(1, 4))
                                               : 3'($urandom_range(0, 7));
          case ($urandom_range(0, 2))
            0:       cols = 6'($urandom_range(1, 8));
            1:       cols = 6'($urandom_range(1, 40));
            default: cols = 6'($urandom_range(0, 63));
          endcase
        end
      endcase
      pad = 6'($urandom);
      write_reg(REG_ROW_COUNT, {pad[5:3], rows});
      write_reg(REG_COL_COUNT, cols);
      start = bus_beats;
      while (bus_beats - start < PHASE_BEATS) random_sequence();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    reg_offset  = '0;
    write_value = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = 1'b0;
    cfg_data    = '0;
    mismatches  = 0;
    cycles      = 0;
    burst_left  = 0;
    bus_beats   = 0;
    stall_mode  = STALL_NONE;
    stall_left  = 0;

    // shadow state at reset
    row_count_q = ROW_COUNT_RST;
    col_count_q = COL_COUNT_RST;
    data_byte   = '0;
    ctrl_bits   = '0;
    cur_row     = '0;
    cur_col     = '0;
    foreach (char_mem[k]) char_mem[k] = 8'h00;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // the store sweep after reset holds in_stall; send_beat waits it out
    test_bus_decode();
    test_characters();
    test_commands();
    test_random_traffic();

    idle_in();
    while (display_events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
